/* sv/gcr_pkg.sv */
package gcr_pkg;

   localparam int ReqDataW = 72;
   localparam int RspDataW = 64;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 13;

   localparam logic [CsrAddrW-1:0] CSR_FB_WIDTH  = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_FB_HEIGHT = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_ASCENDER  = 2'd2;
   localparam logic [CsrAddrW-1:0] CSR_CMODE     = 2'd3;

   localparam logic [12:0] FB_WIDTH_RST  = 13'd320;
   localparam logic [12:0] FB_HEIGHT_RST = 13'd240;

   localparam logic       KIND_HEADER   = 1'b0;
   localparam logic [1:0] CLASS_LITERAL = 2'd0;
   localparam logic [1:0] CLASS_FULL    = 2'd3;

   // request payload, first member in the highest bits
   typedef struct packed {
      logic [7:0]  glyph_cols;
      logic [7:0]  glyph_rows;
      logic [7:0]  glyph_top;
      logic [7:0]  glyph_left;
      logic [12:0] pen_y;
      logic [12:0] pen_x;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic        in_bounds;
      logic [7:0]  coverage;
      logic [25:0] byte_offset;
      logic [13:0] pixel_y;
      logic [13:0] pixel_x;
   } rsp_item_type;

   typedef enum logic [1:0] {
      COV_BYTE = 2'd0,
      COV_ZERO = 2'd1,
      COV_FULL = 2'd2
   } cov_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   typedef struct packed {
      logic        load_hdr;
      logic        emit;
      cov_sel_type cov_sel;
      logic        run_load;
      logic        run_dec;
      logic        run_clr;
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic       advance;
      logic       glyph_done;
      logic       cmode;
      logic       run_zero;
      logic       run_one;
      logic [1:0] run_class;
      logic       glyph_end;
   } status_type;

endpackage

/* sv/gcr_ctrl.sv */
module gcr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_kind,
   input  logic [1:0]         req_class,
   input  gcr_pkg::status_type sts,
   output gcr_pkg::cmd_type    cmd
);
   import gcr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE) && sts.advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.cov_sel = COV_BYTE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_HEADER) begin
                  cmd.load_hdr = 1'b1;
               end else if (!sts.glyph_done) begin
                  if (!sts.cmode) begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                  end else if (sts.run_zero) begin
                     // control byte: literal count, or a fill run played out in FILL
                     cmd.run_load = 1'b1;
                     if (req_class != CLASS_LITERAL) begin
                        state_in = ST_FILL;
                     end
                  end else if (sts.run_class == CLASS_LITERAL) begin
                     cmd.emit    = 1'b1;
                     cmd.run_dec = 1'b1;
                     cmd.last    = 1'b1;
                  end else begin
                     state_in = ST_FILL;
                  end
               end
            end
         end
         ST_FILL: begin
            if (sts.advance) begin
               cmd.emit    = 1'b1;
               cmd.run_dec = 1'b1;
               cmd.cov_sel = (sts.run_class == CLASS_FULL) ? COV_FULL : COV_ZERO;
               if (sts.run_one || sts.glyph_end) begin
                  cmd.last    = 1'b1;
                  cmd.run_clr = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/gcr_dpath.sv */
module gcr_dpath #(
   parameter int MAX_DIM         = 4096,
   parameter int BYTES_PER_PIXEL = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [1:0]              csr_addr,
   input  logic [12:0]             csr_wdata,
   input  gcr_pkg::req_item_type   req_item,
   input  gcr_pkg::cmd_type        cmd,
   output gcr_pkg::status_type     sts,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output gcr_pkg::rsp_item_type   rsp_item,
   output logic                    rsp_tlast
);
   import gcr_pkg::*;

   localparam logic [13:0] MaxDim = 14'(MAX_DIM);
   localparam logic [2:0]  Bpp    = 3'(BYTES_PER_PIXEL);

   // configuration
   logic [12:0]        fb_width_ff;
   logic [12:0]        fb_height_ff;
   logic signed [8:0]  ascender_ff;
   logic               cmode_ff;

   // glyph walk
   logic signed [13:0] base_x_ff, base_x_in;
   logic signed [13:0] base_y_ff, base_y_in;
   logic [7:0]         rows_ff, rows_in;
   logic [7:0]         cols_ff, cols_in;
   logic [7:0]         row_ff, row_in;
   logic [7:0]         col_ff, col_in;
   logic [6:0]         run_left_ff, run_left_in;
   logic [1:0]         run_class_ff, run_class_in;
   logic               done_ff, done_in;

   // pixel pipeline
   logic               advance;
   logic               col_end;
   logic               row_end;
   logic               glyph_end;
   logic [12:0]        w_clip;
   logic [12:0]        h_clip;
   logic [13:0]        px;
   logic [13:0]        py;
   logic               inb;
   logic [25:0]        prod;
   logic [7:0]         cov;

   logic               s1_valid_ff;
   logic [13:0]        s1_px_ff;
   logic [13:0]        s1_py_ff;
   logic [25:0]        s1_prod_ff;
   logic               s1_inb_ff;
   logic [7:0]         s1_cov_ff;
   logic               s1_last_ff;

   logic [26:0]        off_sum;
   logic [29:0]        off_full;
   rsp_item_type       s2_item_in;
   rsp_item_type       s2_item_ff;
   logic               s2_valid_ff;
   logic               s2_last_ff;

   assign advance   = !s2_valid_ff || rsp_tready;
   assign col_end   = (col_ff == cols_ff - 8'd1);
   assign row_end   = (row_ff == rows_ff - 8'd1);
   assign glyph_end = col_end && row_end;

   assign sts.advance    = advance;
   assign sts.glyph_done = done_ff;
   assign sts.cmode      = cmode_ff;
   assign sts.run_zero   = (run_left_ff == 7'd0);
   assign sts.run_one    = (run_left_ff == 7'd1);
   assign sts.run_class  = run_class_ff;
   assign sts.glyph_end  = glyph_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_width_ff  <= FB_WIDTH_RST;
         fb_height_ff <= FB_HEIGHT_RST;
         ascender_ff  <= '0;
         cmode_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FB_WIDTH:  fb_width_ff  <= csr_wdata;
            CSR_FB_HEIGHT: fb_height_ff <= csr_wdata;
            CSR_ASCENDER:  ascender_ff  <= csr_wdata[8:0];
            CSR_CMODE:     cmode_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      base_x_in    = base_x_ff;
      base_y_in    = base_y_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      run_left_in  = run_left_ff;
      run_class_in = run_class_ff;
      done_in      = done_ff;
      if (cmd.load_hdr) begin
         base_x_in = 14'($signed(req_item.pen_x)) + 14'($signed(req_item.glyph_left));
         base_y_in = 14'($signed(req_item.pen_y)) + 14'(ascender_ff)
                     - 14'($signed(req_item.glyph_top));
         rows_in      = req_item.glyph_rows;
         cols_in      = req_item.glyph_cols;
         row_in       = '0;
         col_in       = '0;
         run_left_in  = '0;
         run_class_in = '0;
         done_in      = (req_item.glyph_rows == 8'd0) || (req_item.glyph_cols == 8'd0);
      end else begin
         if (cmd.run_load) begin
            run_left_in  = {1'b0, req_item.data_byte[5:0]} + 7'd1;
            run_class_in = req_item.data_byte[7:6];
         end else if (cmd.run_dec) begin
            run_left_in = run_left_ff - 7'd1;
         end
         if (cmd.run_clr) begin
            run_left_in = '0;
         end
         if (cmd.emit) begin
            if (col_end) begin
               col_in = '0;
               row_in = row_ff + 8'd1;
               if (row_end) begin
                  done_in     = 1'b1;
                  run_left_in = '0;
               end
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff    <= '0;
         base_y_ff    <= '0;
         rows_ff      <= '0;
         cols_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         run_left_ff  <= '0;
         run_class_ff <= '0;
         done_ff      <= 1'b1;
      end else begin
         base_x_ff    <= base_x_in;
         base_y_ff    <= base_y_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         run_left_ff  <= run_left_in;
         run_class_ff <= run_class_in;
         done_ff      <= done_in;
      end
   end

   // stage 1: position, clip and row product
   always_comb begin
      w_clip = ({1'b0, fb_width_ff} > MaxDim) ? MaxDim[12:0] : fb_width_ff;
      h_clip = ({1'b0, fb_height_ff} > MaxDim) ? MaxDim[12:0] : fb_height_ff;
      px     = base_x_ff + {6'd0, col_ff};
      py     = base_y_ff + {6'd0, row_ff};
      inb    = !px[13] && (px[12:0] < w_clip) && !py[13] && (py[12:0] < h_clip);
      prod   = {13'd0, py[12:0]} * {13'd0, w_clip};
      case (cmd.cov_sel)
         COV_ZERO: cov = 8'h00;
         COV_FULL: cov = 8'hff;
         default:  cov = req_item.data_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff   <= px;
         s1_py_ff   <= py;
         s1_prod_ff <= prod;
         s1_inb_ff  <= inb;
         s1_cov_ff  <= cov;
         s1_last_ff <= cmd.last;
      end
   end

   // stage 2: finish the byte offset
   always_comb begin
      off_sum  = {1'b0, s1_prod_ff} + {14'd0, s1_px_ff[12:0]};
      off_full = {3'd0, off_sum} * {27'd0, Bpp};
      s2_item_in.pixel_x     = s1_px_ff;
      s2_item_in.pixel_y     = s1_py_ff;
      s2_item_in.byte_offset = s1_inb_ff ? off_full[25:0] : 26'd0;
      s2_item_in.coverage    = s1_cov_ff;
      s2_item_in.in_bounds   = s1_inb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_item_ff <= s2_item_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_item   = s2_item_ff;
   assign rsp_tlast  = s2_last_ff;

endmodule

/* sv/glyph_coverage_rle_rasterizer.sv */
// channel | direction | tdata fields (lsb up)                                | tuser | tlast
// req_    | in        | data_byte, pen_x, pen_y, glyph_left, glyph_top,        | kind  | -
//         |           | glyph_rows, glyph_cols (66 bits, padded to 72)         |       |
// rsp_    | out       | pixel_x, pixel_y, byte_offset, coverage, in_bounds     | -     | last_of_item
//         |           | (63 bits, padded to 64)                                |       |
// csr_    | in        | write enable, register index, 13-bit write data        | -     | -
//
// A header, an ignored byte, a plain pixel byte or a literal byte is handled in the cycle it is accepted.
// A fill run control byte starts a run of n pixels (n up to 64): the
// controller holds the request side and emits one pixel per cycle while rsp_ is not stalled.
// An emitted pixel passes the product stage, then the offset stage, before it leaves.
// A stall on rsp_ freezes the whole pixel pipe and drops req_tready.
// Reset is synchronous; no clearing pass, the block is ready right after reset.
module glyph_coverage_rle_rasterizer #(
   parameter int MAX_DIM         = 4096,
   parameter int BYTES_PER_PIXEL = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte[7:0], pen_x[20:8], pen_y[33:21], glyph_left[41:34],
   // glyph_top[49:42], glyph_rows[57:50], glyph_cols[65:58]
   input  logic [71:0] req_tdata,
   // kind[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_x[13:0], pixel_y[27:14], byte_offset[53:28], coverage[61:54],
   // in_bounds[62]
   output logic [63:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [12:0] csr_wdata
);
   import gcr_pkg::*;

   req_item_type req_item;
   rsp_item_type rsp_item;
   cmd_type      cmd;
   status_type   sts;

   assign req_item  = req_tdata[65:0];
   assign rsp_tdata = {1'b0, rsp_item};

   gcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_class  (req_item.data_byte[7:6]),
      .sts        (sts),
      .cmd        (cmd)
   );

   gcr_dpath #(
      .MAX_DIM         (MAX_DIM),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* sv/gcr_checker.sv */
module gcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // clipped pixels carry no offset
   a_clip_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[62] |-> rsp_tdata[53:28] == 26'd0)
      else $error("offset on clipped pixel");

   // in-bounds pixels are never at a negative position
   a_inb_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[62] |-> !rsp_tdata[13] && !rsp_tdata[27])
      else $error("in_bounds pixel at negative position");

   // no request taken while the result side is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken during result stall");

   // pipe empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind glyph_coverage_rle_rasterizer gcr_checker u_gcr_checker (.*);
